FILE: rtl/qrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared widths and the word carried through the divider pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int IN_W     = 32;
    localparam int OUT_W    = 32;
    localparam int C_W      = 31;   // scaled component, |c| <= 2^30
    localparam int ACC_W    = 64;   // products, sums and remainders
    localparam int Q_W      = 31;   // quotient bits before rounding
    localparam int N_ENT    = 9;
    localparam int DIV_STEPS = 31;  // integer bit plus 30 fraction bits

    typedef struct packed {
        logic                          valid;
        logic                          zero;
        logic [ACC_W-1:0]              den;
        logic [N_ENT-1:0][ACC_W-1:0]   rem;
        logic [N_ENT-1:0][Q_W-1:0]     quo;
        logic [N_ENT-1:0]              neg;
    } t_div_word;

endpackage

FILE: rtl/qrm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_front
// Range scaling, the ten products and the quadratic forms, three stages.
// ----------------------------------------------------------------------------
module qrm_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [qrm_pkg::IN_W-1:0]   i_quat_w,
    input  logic signed [qrm_pkg::IN_W-1:0]   i_quat_x,
    input  logic signed [qrm_pkg::IN_W-1:0]   i_quat_y,
    input  logic signed [qrm_pkg::IN_W-1:0]   i_quat_z,
    output qrm_pkg::t_div_word                o_word
);
    import qrm_pkg::*;

    function automatic logic signed [ACC_W-1:0] mul(input logic signed [C_W-1:0] a,
                                                    input logic signed [C_W-1:0] b);
        logic signed [2*C_W-1:0] p;
        p = a * b;
        return {{(ACC_W-2*C_W){p[2*C_W-1]}}, p};
    endfunction

    logic [IN_W-1:0] mag [4];
    logic [3:0]      sgn;
    logic [IN_W-1:0] maxm;
    logic [1:0]      sh;
    logic [IN_W-1:0] sc [4];

    logic                   r_a_valid, r_a_zero;
    logic signed [C_W-1:0]  r_c [4];
    logic signed [C_W-1:0]  n_c [4];

    logic                   r_b_valid, r_b_zero;
    logic signed [ACC_W-1:0] r_p [10];  // ww xx yy zz xy xz yz wx wy wz

    logic signed [ACC_W-1:0] mm [N_ENT];
    t_div_word               n_word, r_word;

    always_comb begin
        mag[0] = i_quat_w[IN_W-1] ? IN_W'(-i_quat_w) : i_quat_w;
        mag[1] = i_quat_x[IN_W-1] ? IN_W'(-i_quat_x) : i_quat_x;
        mag[2] = i_quat_y[IN_W-1] ? IN_W'(-i_quat_y) : i_quat_y;
        mag[3] = i_quat_z[IN_W-1] ? IN_W'(-i_quat_z) : i_quat_z;
        sgn = {i_quat_z[IN_W-1], i_quat_y[IN_W-1], i_quat_x[IN_W-1], i_quat_w[IN_W-1]};
        maxm = mag[0];
        for (int i = 1; i < 4; i++) begin
            if (mag[i] > maxm) maxm = mag[i];
        end
        sh = maxm[IN_W-1] ? 2'd2 : (maxm[IN_W-2] ? 2'd1 : 2'd0);
        for (int i = 0; i < 4; i++) begin
            sc[i]  = mag[i] >> sh;
            n_c[i] = sgn[i] ? -$signed(sc[i][C_W-1:0]) : $signed(sc[i][C_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_zero <= (maxm == '0);
        for (int i = 0; i < 4; i++) r_c[i] <= n_c[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_zero <= r_a_zero;
        r_p[0] <= mul(r_c[0], r_c[0]);
        r_p[1] <= mul(r_c[1], r_c[1]);
        r_p[2] <= mul(r_c[2], r_c[2]);
        r_p[3] <= mul(r_c[3], r_c[3]);
        r_p[4] <= mul(r_c[1], r_c[2]);
        r_p[5] <= mul(r_c[1], r_c[3]);
        r_p[6] <= mul(r_c[2], r_c[3]);
        r_p[7] <= mul(r_c[0], r_c[1]);
        r_p[8] <= mul(r_c[0], r_c[2]);
        r_p[9] <= mul(r_c[0], r_c[3]);
    end

    always_comb begin
        mm[0] = r_p[0] + r_p[1] - r_p[2] - r_p[3];
        mm[1] = (r_p[4] - r_p[9]) <<< 1;
        mm[2] = (r_p[5] + r_p[8]) <<< 1;
        mm[3] = (r_p[4] + r_p[9]) <<< 1;
        mm[4] = r_p[0] - r_p[1] + r_p[2] - r_p[3];
        mm[5] = (r_p[6] - r_p[7]) <<< 1;
        mm[6] = (r_p[5] - r_p[8]) <<< 1;
        mm[7] = (r_p[6] + r_p[7]) <<< 1;
        mm[8] = r_p[0] - r_p[1] - r_p[2] + r_p[3];
        n_word.valid = r_b_valid;
        n_word.zero  = r_b_zero;
        n_word.den   = r_p[0] + r_p[1] + r_p[2] + r_p[3];
        for (int i = 0; i < N_ENT; i++) begin
            n_word.neg[i] = mm[i][ACC_W-1];
            n_word.rem[i] = mm[i][ACC_W-1] ? ACC_W'(-mm[i]) : mm[i];
            n_word.quo[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else begin
            r_word.valid <= n_word.valid;
        end
        r_word.zero <= n_word.zero;
        r_word.den  <= n_word.den;
        r_word.rem  <= n_word.rem;
        r_word.quo  <= n_word.quo;
        r_word.neg  <= n_word.neg;
    end

    assign o_word = r_word;

endmodule

FILE: rtl/qrm_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_div_stage
// One restoring division step for all nine entries against the shared norm.
// ----------------------------------------------------------------------------
module qrm_div_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qrm_pkg::t_div_word i_word,
    output qrm_pkg::t_div_word o_word
);
    import qrm_pkg::*;

    t_div_word  n_word, r_word;
    logic [ACC_W-1:0] diff;
    logic       b;

    always_comb begin
        n_word = i_word;
        diff = '0;
        b = 1'b0;
        for (int i = 0; i < N_ENT; i++) begin
            b    = (i_word.rem[i] >= i_word.den);
            diff = b ? (i_word.rem[i] - i_word.den) : i_word.rem[i];
            n_word.rem[i] = diff << 1;
            n_word.quo[i] = {i_word.quo[i][Q_W-2:0], b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else begin
            r_word.valid <= n_word.valid;
        end
        r_word.zero <= n_word.zero;
        r_word.den  <= n_word.den;
        r_word.rem  <= n_word.rem;
        r_word.quo  <= n_word.quo;
        r_word.neg  <= n_word.neg;
    end

    assign o_word = r_word;

endmodule

FILE: rtl/quaternion_to_rotation_matrix_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core
// Unit-normalized quaternion (Q16.16) to 3x3 rotation matrix (Q1.30).
// ----------------------------------------------------------------------------
// A word enters on any cycle with i_start high; o_busy is always low. Each
// result appears for one cycle with o_valid high, once its word has passed through
// three front stages (scaling, products, sums), 31 divider steps and one rounding
// stage. The divider is a 31-step restoring pipeline shared by the nine
// entries. The receiver cannot stall, so results must be taken when strobed.
// A zero quaternion gives a zero matrix with o_zero_norm set.
module quaternion_to_rotation_matrix_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [qrm_pkg::IN_W-1:0]    i_quat_w,
    input  logic signed [qrm_pkg::IN_W-1:0]    i_quat_x,
    input  logic signed [qrm_pkg::IN_W-1:0]    i_quat_y,
    input  logic signed [qrm_pkg::IN_W-1:0]    i_quat_z,
    output logic                               o_valid,
    output logic signed [qrm_pkg::OUT_W-1:0]   o_m00,
    output logic signed [qrm_pkg::OUT_W-1:0]   o_m01,
    output logic signed [qrm_pkg::OUT_W-1:0]   o_m02,
    output logic signed [qrm_pkg::OUT_W-1:0]   o_m10,
    output logic signed [qrm_pkg::OUT_W-1:0]   o_m11,
    output logic signed [qrm_pkg::OUT_W-1:0]   o_m12,
    output logic signed [qrm_pkg::OUT_W-1:0]   o_m20,
    output logic signed [qrm_pkg::OUT_W-1:0]   o_m21,
    output logic signed [qrm_pkg::OUT_W-1:0]   o_m22,
    output logic                               o_zero_norm
);
    import qrm_pkg::*;

    t_div_word w [DIV_STEPS+1];
    logic [N_ENT-1:0][OUT_W-1:0] n_m, r_m;
    logic [OUT_W-1:0] qf;
    logic r_valid, r_zero;

    assign o_busy = 1'b0;

    qrm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_start),
        .i_quat_w (i_quat_w),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .o_word   (w[0])
    );

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        qrm_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (w[g]),
            .o_word  (w[g+1])
        );
    end

    // final step rounds half away from zero and applies the sign
    always_comb begin
        qf = '0;
        for (int i = 0; i < N_ENT; i++) begin
            qf = {1'b0, w[DIV_STEPS].quo[i]}
                 + OUT_W'(w[DIV_STEPS].rem[i] >= w[DIV_STEPS].den);
            if (w[DIV_STEPS].zero)
                n_m[i] = '0;
            else
                n_m[i] = w[DIV_STEPS].neg[i] ? -qf : qf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w[DIV_STEPS].valid;
        end
        r_zero <= w[DIV_STEPS].zero;
        r_m    <= n_m;
    end

    assign o_valid     = r_valid;
    assign o_zero_norm = r_zero;
    assign o_m00 = r_m[0];
    assign o_m01 = r_m[1];
    assign o_m02 = r_m[2];
    assign o_m10 = r_m[3];
    assign o_m11 = r_m[4];
    assign o_m12 = r_m[5];
    assign o_m20 = r_m[6];
    assign o_m21 = r_m[7];
    assign o_m22 = r_m[8];

endmodule

FILE: dv/quaternion_to_rotation_matrix_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core_test
// Drives quaternions through the core and checks each rotation matrix word
// against an exact normalize-and-round predictor, under varied start gaps.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_core_test;

    typedef struct packed {
        logic signed [31:0] w, x, y, z;
    } t_quat;

    typedef struct {
        logic signed [31:0] m [9];
        logic               zero;
    } t_mat;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic              o_busy;
    logic signed [31:0] i_quat_w = '0, i_quat_x = '0, i_quat_y = '0, i_quat_z = '0;
    logic              o_valid;
    logic signed [31:0] o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;
    logic              o_zero_norm;

    t_mat  expected_mats [$];
    int    n_errors = 0;
    int    n_results = 0;
    int    n_sent = 0;
    int    cycle_count = 0;
    int    gap_pct = 0;

    localparam int LATENCY = 35;
    localparam int CYCLE_LIMIT = 400000;

    quaternion_to_rotation_matrix_core dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("quaternion_to_rotation_matrix_core_test: FAIL");
            $finish;
        end
    end

    // round(|num| * 2^30 / den), ties away from zero, sign of num
    function automatic logic signed [31:0] div_round(longint num, longint unsigned den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (num < 0) ? 128'(-num) : 128'(num);
        q = ((mag << 31) / den + 1) >> 1;
        return (num < 0) ? -32'(q) : 32'(q);
    endfunction

    function automatic t_mat rotation_of(t_quat q);
        t_mat r;
        longint c [4];
        longint unsigned mx, mg [4];
        int sh;
        longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint e [9];
        longint unsigned n2;
        c[0] = q.w; c[1] = q.x; c[2] = q.y; c[3] = q.z;
        mx = 0;
        for (int i = 0; i < 4; i++) begin
            mg[i] = (c[i] < 0) ? -c[i] : c[i];
            if (mg[i] > mx) mx = mg[i];
        end
        r.zero = (mx == 0);
        for (int i = 0; i < 9; i++) r.m[i] = '0;
        if (r.zero) return r;
        sh = (mx < (64'd1 << 30)) ? 0 : ((mx < (64'd1 << 31)) ? 1 : 2);
        for (int i = 0; i < 4; i++)
            c[i] = (c[i] < 0) ? -longint'(mg[i] >> sh) : longint'(mg[i] >> sh);
        ww = c[0]*c[0]; xx = c[1]*c[1]; yy = c[2]*c[2]; zz = c[3]*c[3];
        xy = c[1]*c[2]; xz = c[1]*c[3]; yz = c[2]*c[3];
        wx = c[0]*c[1]; wy = c[0]*c[2]; wz = c[0]*c[3];
        n2 = ww + xx + yy + zz;
        e[0] = ww + xx - yy - zz;  e[1] = 2*(xy - wz);  e[2] = 2*(xz + wy);
        e[3] = 2*(xy + wz);  e[4] = ww - xx + yy - zz;  e[5] = 2*(yz - wx);
        e[6] = 2*(xz - wy);  e[7] = 2*(yz + wx);  e[8] = ww - xx - yy + zz;
        for (int i = 0; i < 9; i++) r.m[i] = div_round(e[i], n2);
        return r;
    endfunction

    // start stays high into the next word unless a gap or a drain drops it
    task automatic send_quat(t_quat q);
        while ($urandom_range(99) < gap_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start  <= 1'b1;
        i_quat_w <= q.w; i_quat_x <= q.x; i_quat_y <= q.y; i_quat_z <= q.z;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        expected_mats.push_back(rotation_of(q));
        n_sent++;
    endtask

    // checker: sample at the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        logic signed [31:0] got [9];
        t_mat exp_m;
        bit bad;
        if (i_rst_n && o_valid) begin
            got = '{o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22};
            n_results++;
            if (expected_mats.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result word");
            end else begin
                exp_m = expected_mats.pop_front();
                bad = (o_zero_norm !== exp_m.zero);
                for (int i = 0; i < 9; i++) if (got[i] !== exp_m.m[i]) bad = 1;
                if (bad) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("mismatch word %0d: zero exp %b got %b", n_results,
                                 exp_m.zero, o_zero_norm);
                        for (int i = 0; i < 9; i++)
                            $display("  m%0d%0d exp %h got %h", i/3, i%3, exp_m.m[i], got[i]);
                    end
                end
            end
        end
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1, 1 << 20) * ($urandom_range(1) ? 1 : -1);
            2: return $urandom_range(0, 3) - 2;
            3: return {$urandom_range(1) ? 2'b10 : 2'b01, 30'($urandom)};
            4: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return $urandom_range(0, 1 << 17) - (1 << 16);
        endcase
    endfunction

    task automatic wait_drained();
        i_start <= 1'b0;
        while (expected_mats.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_quat('{0, 0, 0, 0});
        send_quat('{32'sh10000, 0, 0, 0});
        send_quat('{0, 32'sh10000, 0, 0});
        send_quat('{0, 0, 32'sh10000, 0});
        send_quat('{0, 0, 0, 32'sh10000});
        send_quat('{-32'sh10000, 0, 0, 0});
        send_quat('{1, 0, 0, 0});
        send_quat('{0, -1, 0, 0});
        send_quat('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
        send_quat('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff});
        send_quat('{32'sh8000_0000, 0, 0, 1});
        send_quat('{32'sh3fff_ffff, 32'sh4000_0000, 0, 0});     // shift by one
        send_quat('{32'sh3fff_ffff, -32'sh3fff_ffff, 5, -7});   // no shift, largest
        send_quat('{32'sh7fff_ffff, 32'sh8000_0001, 3, 0});
        send_quat('{1, 1, 1, 1});
        send_quat('{1, -1, 1, -1});
        send_quat('{32'sh0000b505, 32'sh0000b505, 0, 0});
        send_quat('{-1, -1, -1, -1});
        send_quat('{32'shffff_ffff, 0, 0, 32'sh7fff_ffff});
        // hold off until every result is in
        wait_drained();
        send_quat('{0, 0, 0, 0});
    endtask

    task automatic test_random(int n, int pct);
        t_quat q;
        gap_pct = pct;
        for (int k = 0; k < n; k++) begin
            q = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
            if ($urandom_range(49) == 0) q = '0;
            send_quat(q);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(550, 26);
        test_random(550, 76);
        test_random(550, 0);
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("sent %0d quaternions (zero, extremes, shifted and random), checked %0d",
                 n_sent, n_results);
        $display("%0d mismatches", n_errors);
        if (n_errors == 0 && expected_mats.size() == 0)
            $display("quaternion_to_rotation_matrix_core_test: PASS");
        else
            $display("quaternion_to_rotation_matrix_core_test: FAIL");
        $finish;
    end

endmodule
